// ===== sv/rtlfc_pkg.sv =====
// Package for the region table lookup and fault check block.
// Holds the shared types, operation and status codes and default sizes.
// No dependencies.
package rtlfc_pkg;

    // Default table depth.
    localparam int MAX_REGIONS_DEF = 32;

    // Field widths.
    localparam int ADDR_W   = 32;
    localparam int FLAGS_W  = 3;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 6;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_FAULT  = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DENIED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // Flag bits and access codes.
    localparam int FL_READ_BIT  = 0;
    localparam int FL_WRITE_BIT = 1;
    localparam int FL_EXEC_BIT  = 2;
    localparam logic [1:0] ACC_READ_ABSENT   = 2'd0;
    localparam logic [1:0] ACC_PRESENT_RD    = 2'd1;
    localparam logic [1:0] ACC_WRITE_ABSENT  = 2'd2;
    localparam logic [1:0] ACC_WRITE_PRESENT = 2'd3;

    // One stored region.
    typedef struct packed {
        logic [ADDR_W-1:0]  rstart;
        logic [ADDR_W-1:0]  rend;
        logic [FLAGS_W-1:0] rflags;
    } entry_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  rstart;
        logic [ADDR_W-1:0]  rend;
        logic [FLAGS_W-1:0] rflags;
        logic               commit;
    } cell_cmd_t;

    // Compare results of one cell.
    typedef struct packed {
        logic le;
        logic match;
        logic ovl;
    } cell_stat_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

// ===== sv/region_table_lookup_fault_check.sv =====
// Each item is captured in the idle state; the execute state then compares it with
// all cells of the chain in parallel, shifts the chain on an insert and writes the
// result register. No new item is accepted until the execute state ends, and that
// state waits while the output register still holds an untaken result.
// Reset (aresetn, synchronous, active low) empties the table and clears the handshake.
module region_table_lookup_fault_check #(
    parameter int MAX_REGIONS = rtlfc_pkg::MAX_REGIONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_operation,
    input  logic [rtlfc_pkg::ADDR_W-1:0]     s_addr,
    input  logic [rtlfc_pkg::ADDR_W-1:0]     s_region_start,
    input  logic [rtlfc_pkg::ADDR_W-1:0]     s_region_end,
    input  logic [rtlfc_pkg::FLAGS_W-1:0]    s_region_flags,
    input  logic [1:0]                       s_access_code,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rtlfc_pkg::STATUS_W-1:0]   m_status,
    output logic                             m_region_found,
    output logic [rtlfc_pkg::ADDR_W-1:0]     m_found_start,
    output logic [rtlfc_pkg::ADDR_W-1:0]     m_found_end,
    output logic [rtlfc_pkg::FLAGS_W-1:0]    m_found_flags,
    output logic                             m_grant_write,
    output logic [rtlfc_pkg::USED_W-1:0]     m_entries_used
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    rtlfc_pkg::state_t state_reg, state_next;

    logic [1:0]                     op_reg;
    logic [rtlfc_pkg::ADDR_W-1:0]   addr_reg;
    logic [rtlfc_pkg::ADDR_W-1:0]   rs_reg;
    logic [rtlfc_pkg::ADDR_W-1:0]   re_reg;
    logic [rtlfc_pkg::FLAGS_W-1:0]  rf_reg;
    logic [1:0]                     acc_reg;
    logic [CNT_W-1:0]               count_reg, count_next;

    logic                           m_valid_reg;
    logic [rtlfc_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                           found_reg;
    rtlfc_pkg::entry_t              found_entry_reg;
    logic                           grant_reg, grant_next;
    logic [rtlfc_pkg::USED_W-1:0]   used_reg;

    logic                           exec_fire;
    rtlfc_pkg::cell_cmd_t           cmd;
    rtlfc_pkg::entry_t              chain [MAX_REGIONS];
    rtlfc_pkg::entry_t              sel   [MAX_REGIONS];
    rtlfc_pkg::cell_stat_t          stat  [MAX_REGIONS];
    logic [MAX_REGIONS-1:0]         first_vec;
    rtlfc_pkg::entry_t              hit;
    logic                           found;
    logic                           ovl_any;
    logic                           fault_ok;

    assign s_ready   = (state_reg == rtlfc_pkg::ST_IDLE);
    assign exec_fire = (state_reg == rtlfc_pkg::ST_EXEC) && (!m_valid_reg || m_ready);

    // Command broadcast to the chain.
    assign cmd.addr   = addr_reg;
    assign cmd.rstart = rs_reg;
    assign cmd.rend   = re_reg;
    assign cmd.rflags = rf_reg;
    assign cmd.commit = exec_fire && (op_reg == rtlfc_pkg::OP_INSERT) &&
                        (status_next == rtlfc_pkg::ST_OK);

    // The chain of cells, each one entry of the sorted table.
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        rtlfc_pkg::entry_t left_entry;
        logic              left_le;
        logic              left_match;
        logic              right_le;

        if (g == 0) begin : g_head
            assign left_entry = '0;
            assign left_le    = 1'b1;
            assign left_match = 1'b0;
        end else begin : g_body
            assign left_entry = chain[g-1];
            assign left_le    = stat[g-1].le;
            assign left_match = stat[g-1].match;
        end

        if (g == MAX_REGIONS - 1) begin : g_tail
            assign right_le = 1'b0;
        end else begin : g_mid
            assign right_le = stat[g+1].le;
        end

        rtlfc_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .cell_valid (CNT_W'(g) < count_reg),
            .left_entry (left_entry),
            .left_le    (left_le),
            .left_match (left_match),
            .right_le   (right_le),
            .entry      (chain[g]),
            .sel_entry  (sel[g]),
            .stat       (stat[g])
        );

        assign first_vec[g] = stat[g].match && !left_match;
    end

    // Gather the hit entry and the overlap flags from all cells.
    always_comb begin
        hit     = '0;
        ovl_any = 1'b0;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            hit     = hit | sel[i];
            ovl_any = ovl_any | stat[i].ovl;
        end
    end

    assign found = |first_vec;

    // Access check against the region that covers the address.
    always_comb begin
        fault_ok = 1'b0;
        if (found && (hit.rstart <= addr_reg)) begin
            priority if (acc_reg == rtlfc_pkg::ACC_PRESENT_RD) begin
                fault_ok = 1'b0;
            end else if (acc_reg == rtlfc_pkg::ACC_READ_ABSENT) begin
                fault_ok = hit.rflags[rtlfc_pkg::FL_READ_BIT] ||
                           hit.rflags[rtlfc_pkg::FL_EXEC_BIT];
            end else begin
                fault_ok = hit.rflags[rtlfc_pkg::FL_WRITE_BIT];
            end
        end
    end

    // Status, grant and count for the item in execution.
    always_comb begin
        status_next = rtlfc_pkg::ST_OK;
        grant_next  = 1'b0;
        count_next  = count_reg;
        unique case (op_reg)
            rtlfc_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            rtlfc_pkg::OP_INSERT: begin
                priority if (rs_reg >= re_reg) begin
                    status_next = rtlfc_pkg::ST_EMPTY;
                end else if (ovl_any) begin
                    status_next = rtlfc_pkg::ST_OVERLAP;
                end else if (count_reg >= CNT_W'(MAX_REGIONS)) begin
                    status_next = rtlfc_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            rtlfc_pkg::OP_LOOKUP: begin
                status_next = found ? rtlfc_pkg::ST_OK : rtlfc_pkg::ST_DENIED;
            end
            default: begin
                status_next = fault_ok ? rtlfc_pkg::ST_OK : rtlfc_pkg::ST_DENIED;
                grant_next  = fault_ok && hit.rflags[rtlfc_pkg::FL_WRITE_BIT];
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rtlfc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rtlfc_pkg::ST_EXEC;
                end
            end
            rtlfc_pkg::ST_EXEC: begin
                if (exec_fire) begin
                    state_next = rtlfc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rtlfc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rtlfc_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Input item capture.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            addr_reg <= s_addr;
            rs_reg   <= s_region_start;
            re_reg   <= s_region_end;
            rf_reg   <= s_region_flags;
            acc_reg  <= s_access_code;
        end
    end

    // Result register; clear and insert report no region.
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
            used_reg   <= rtlfc_pkg::USED_W'(count_next);
            if (op_reg == rtlfc_pkg::OP_LOOKUP || op_reg == rtlfc_pkg::OP_FAULT) begin
                found_reg       <= found;
                found_entry_reg <= hit;
            end else begin
                found_reg       <= 1'b0;
                found_entry_reg <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_region_found = found_reg;
    assign m_found_start  = found_entry_reg.rstart;
    assign m_found_end    = found_entry_reg.rend;
    assign m_found_flags  = found_entry_reg.rflags;
    assign m_grant_write  = grant_reg;
    assign m_entries_used = used_reg;

    // The table never holds more regions than it has cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count exceeds table depth");

    // At most one cell reports itself as the first hit.
    a_first_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(first_vec))
        else $error("more than one first hit in the chain");

    // A committed insert grows the table by exactly one region.
    a_insert_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the table by one");

    // A clear leaves the table empty.
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && op_reg == rtlfc_pkg::OP_CLEAR) |=> count_reg == '0)
        else $error("clear did not empty the table");

endmodule

// ===== sv/rtlfc_cell.sv =====
// One cell of the sorted region chain: holds one region and its compares.
// Depends on rtlfc_pkg.
module rtlfc_cell (
    input  logic                   aclk,
    input  rtlfc_pkg::cell_cmd_t   cmd,
    input  logic                   cell_valid,
    input  rtlfc_pkg::entry_t      left_entry,
    input  logic                   left_le,
    input  logic                   left_match,
    input  logic                   right_le,
    output rtlfc_pkg::entry_t      entry,
    output rtlfc_pkg::entry_t      sel_entry,
    output rtlfc_pkg::cell_stat_t  stat
);

    rtlfc_pkg::entry_t entry_reg;
    rtlfc_pkg::entry_t new_entry;
    logic              le;
    logic              match;
    logic              first;

    assign new_entry = '{rstart: cmd.rstart, rend: cmd.rend, rflags: cmd.rflags};

    // Local compares; valid cells form a prefix, so le is a thermometer code and match is one contiguous run.
    assign le    = cell_valid && (entry_reg.rstart <= cmd.rstart);
    assign match = cell_valid && (entry_reg.rend > cmd.addr);
    assign first = match && !left_match;

    // Overlap with the left neighbor of the slot or with the entry now in the slot.
    assign stat.le    = le;
    assign stat.match = match;
    assign stat.ovl   = (le && !right_le && (entry_reg.rend > cmd.rstart)) ||
                        (!le && left_le && cell_valid && (cmd.rend > entry_reg.rstart));

    assign entry     = entry_reg;
    assign sel_entry = first ? entry_reg : '0;

    // On insert, the slot cell loads the new region and the cells after it shift right.
    always_ff @(posedge aclk) begin
        if (cmd.commit && !le) begin
            if (left_le) begin
                entry_reg <= new_entry;
            end else begin
                entry_reg <= left_entry;
            end
        end
    end

endmodule
